FILE: sv/tlli_pkg.sv
// tlli_pkg: shared types and constants for the lookup table interpolation unit
// depends on nothing; imported by every module of the block but tlli_ram
package tlli_pkg;

    localparam int POINTS     = 256;
    localparam int COLS       = 8;
    localparam int ROW_W      = $clog2(POINTS);
    localparam int COL_W      = $clog2(COLS);
    localparam int SMP_AW     = ROW_W + COL_W;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = 64;
    // quotient bits that are ever needed before the clamp at 2^33
    localparam int QUO_W      = 35;
    localparam int QOUT_W     = 34;
    localparam logic [QUO_W-1:0] QUO_LIMIT = QUO_W'(64'h2_0000_0000);

    localparam logic [1:0] OP_LOAD_BP   = 2'd0;
    localparam logic [1:0] OP_LOAD_DATA = 2'd1;
    localparam logic [1:0] OP_LOOKUP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    localparam logic [1:0] CFG_NUM_POINTS  = 2'd0;
    localparam logic [1:0] CFG_NUM_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_ASCENDING   = 2'd2;
    localparam logic [1:0] CFG_MIN_SPACING = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        row_index;
        logic [2:0]        column_index;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0]        column;
        logic signed [31:0] result_value;
        logic [1:0]        status;
        logic              last;
    } out_t;

endpackage

FILE: sv/tlli_ram.sv
// tlli_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
module tlli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/tlli_div.sv
// tlli_div: one-bit-per-cycle restoring divider, quotient clamped to 2^33
// depends on tlli_pkg
module tlli_div
    import tlli_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [VAL_W-1:0]    divisor,
    output logic                done,
    output logic [QOUT_W-1:0]   quotient
);

    logic [VAL_W-1:0]         rem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [$clog2(QUO_W):0]   cnt_reg;
    logic                     run_reg;
    logic                     done_reg;
    logic                     ovf_reg;
    logic [VAL_W:0]           trial;
    logic                     ge;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            // quotient at least 2^35 goes straight to the clamp
            if (VAL_W'(dividend[PROD_W-1:QUO_W]) >= divisor)
            begin
                ovf_reg  <= 1'b1;
                done_reg <= 1'b1;
                run_reg  <= 1'b0;
            end
            else
            begin
                ovf_reg  <= 1'b0;
                done_reg <= 1'b0;
                run_reg  <= 1'b1;
                cnt_reg  <= ($clog2(QUO_W)+1)'(QUO_W);
            end
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= VAL_W'(dividend[PROD_W-1:QUO_W]);
            quo_reg <= dividend[QUO_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? VAL_W'(trial - {1'b0, divisor}) : trial[VAL_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = (ovf_reg || quo_reg > QUO_LIMIT) ? QOUT_W'(QUO_LIMIT)
                                                       : quo_reg[QOUT_W-1:0];

    // a quotient that has not overflowed needs a remainder below the divisor
    ap_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && !start |=> rem_reg < divisor || !run_reg)
        else $error("divider remainder out of range");

    ap_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && cnt_reg == 1 && !start |=> done_reg)
        else $error("divider did not finish");

    ap_quotient_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> quotient <= QOUT_W'(QUO_LIMIT))
        else $error("divider quotient above clamp");

endmodule

FILE: sv/table_lookup_linear_interp_unit.sv
// table_lookup_linear_interp_unit: breakpoint search and per-column interpolation
// depends on tlli_pkg, tlli_ram, tlli_div
// loads write their ram while idle, busy low; a lookup with one point skips the search, else it
// checks the first breakpoint, then the last, and for a target between them halves the bracket
// step by step; each interpolated column runs the 35-step divider (skipped on quotient overflow),
// clamped or degenerate ones bypass it; busy is high throughout, results leave one per strobe the
// cycle after each column ends and cannot be stalled; an empty table answers next cycle, busy low
// reset (rst_n, asynchronous) restores the config registers; table contents are not cleared
module table_lookup_linear_interp_unit
    import tlli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         cmd,
    output logic        result_valid,
    output out_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_RDF, S_CKF, S_RDL, S_CKL, S_SRD, S_SCK,
        S_Y0, S_Y1, S_MUL, S_PROD, S_DIVGO, S_DIV
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [8:0]  num_points_reg;
    logic [3:0]  num_columns_reg;
    logic        ascending_reg;
    logic [30:0] min_spacing_reg;

    // lookup context
    logic signed [31:0] target_reg;
    logic [ROW_W:0]     n_reg;
    logic [COL_W:0]     nc_reg;
    logic [ROW_W-1:0]   lo_reg, hi_reg;
    logic signed [31:0] xlo_reg;
    logic [31:0]        dt_mag_reg, dx_mag_reg;
    logic               dt_neg_reg, dx_neg_reg;
    logic               degen_reg;
    logic [COL_W-1:0]   col_reg;
    logic signed [31:0] y0_reg;
    logic [31:0]        dy_mag_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;

    // memories
    logic [ROW_W-1:0]   bp_raddr;
    logic [31:0]        bp_rdata;
    logic [SMP_AW-1:0]  smp_raddr;
    logic [31:0]        smp_rdata;
    logic               do_load;

    logic               div_done;
    logic [QOUT_W-1:0]  div_q;

    logic [ROW_W:0]     mid_sum;
    logic [ROW_W-1:0]   mid;
    logic signed [31:0] rd_val;
    logic               below_first, above_last, go_low;
    logic signed [32:0] dt_full, dx_full, dy_full;
    logic signed [32:0] dt_mid, dx_cur, dx_mid;
    logic signed [35:0] sum_full;
    logic signed [31:0] sum_sat;
    logic               last_col;
    logic [ROW_W:0]     n_eff;
    logic [COL_W:0]     nc_eff;

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign do_load   = start && !busy;

    // clamp register values above the table size
    assign n_eff  = (num_points_reg > 9'(POINTS)) ? (ROW_W+1)'(POINTS)
                                                  : (ROW_W+1)'(num_points_reg);
    assign nc_eff = (num_columns_reg > 4'(COLS)) ? (COL_W+1)'(COLS)
                                                 : (COL_W+1)'(num_columns_reg);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[ROW_W:1];
    assign rd_val  = $signed(bp_rdata);

    assign below_first = ascending_reg ? (target_reg <= rd_val) : (target_reg >= rd_val);
    assign above_last  = ascending_reg ? (target_reg >= rd_val) : (target_reg <= rd_val);
    assign go_low      = ascending_reg ? (rd_val <= target_reg) : (rd_val >= target_reg);

    assign dt_full = 33'(target_reg) - 33'(xlo_reg);
    assign dx_full = 33'(rd_val) - 33'(xlo_reg);
    assign dy_full = 33'($signed(smp_rdata)) - 33'(y0_reg);

    // gaps seen from the probed point when it becomes the new lower end
    assign dt_mid = 33'(target_reg) - 33'(rd_val);
    assign dx_cur = dx_neg_reg ? -$signed({1'b0, dx_mag_reg}) : $signed({1'b0, dx_mag_reg});
    assign dx_mid = 33'(xlo_reg) + dx_cur - 33'(rd_val);

    // y0 +/- clamped quotient, then saturate to 32 bits
    assign sum_full = 36'(y0_reg) + (neg_reg ? -$signed({2'b00, div_q})
                                             :  $signed({2'b00, div_q}));
    assign sum_sat  = (sum_full > 36'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (sum_full < -36'sh0_8000_0000) ? -32'sh8000_0000 : sum_full[31:0];

    assign last_col = ({1'b0, col_reg} + 1'b1) == nc_reg;

    always_comb
    begin
        bp_raddr  = '0;
        smp_raddr = {lo_reg, col_reg};
        unique case (state_reg)
            S_RDL:   bp_raddr = n_reg[ROW_W-1:0] - 1'b1;
            S_SRD:   bp_raddr = mid;
            S_Y1:    smp_raddr = {hi_reg, col_reg};
            default: ;
        endcase
    end

    tlli_ram #(.WIDTH(VAL_W), .DEPTH(POINTS)) u_bp_ram (
        .clk   (clk),
        .we    (do_load && cmd.operation == OP_LOAD_BP),
        .waddr (cmd.row_index[ROW_W-1:0]),
        .wdata (cmd.value),
        .raddr (bp_raddr),
        .rdata (bp_rdata)
    );

    tlli_ram #(.WIDTH(VAL_W), .DEPTH(POINTS*COLS)) u_smp_ram (
        .clk   (clk),
        .we    (do_load && cmd.operation == OP_LOAD_DATA),
        .waddr ({cmd.row_index[ROW_W-1:0], cmd.column_index[COL_W-1:0]}),
        .wdata (cmd.value),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    tlli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVGO),
        .dividend (prod_reg),
        .divisor  (dx_mag_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (do_load && cmd.operation == OP_LOOKUP && n_eff != 0 && nc_eff != 0)
                begin
                    state_next = (n_eff == 1) ? S_Y0 : S_RDF;
                end
            end
            S_RDF:   state_next = S_CKF;
            S_CKF:   state_next = below_first ? S_Y0 : S_RDL;
            S_RDL:   state_next = S_CKL;
            S_CKL:   state_next = above_last ? S_Y0 : S_SRD;
            S_SRD:   state_next = (mid_sum > ({1'b0, lo_reg} << 1) + 2'd1) ? S_SCK : S_Y0;
            S_SCK:   state_next = S_SRD;
            S_Y0:    state_next = S_Y1;
            S_Y1:    state_next = S_MUL;
            S_MUL:
            begin
                if (lo_reg == hi_reg || degen_reg)
                begin
                    state_next = last_col ? S_IDLE : S_Y0;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = last_col ? S_IDLE : S_Y0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state, config and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_points_reg  <= '0;
            num_columns_reg <= '0;
            ascending_reg   <= 1'b1;
            min_spacing_reg <= 31'd1;
            result_valid    <= 1'b0;
            result          <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NUM_POINTS:  num_points_reg  <= cfg_data[8:0];
                    CFG_NUM_COLUMNS: num_columns_reg <= cfg_data[3:0];
                    CFG_ASCENDING:   ascending_reg   <= cfg_data[0];
                    CFG_MIN_SPACING: min_spacing_reg <= cfg_data[30:0];
                endcase
            end
            // empty table gives a single error item
            if (state_reg == S_IDLE && do_load && cmd.operation == OP_LOOKUP
                && (n_eff == 0 || nc_eff == 0))
            begin
                result_valid        <= 1'b1;
                result.column       <= '0;
                result.result_value <= '0;
                result.status       <= ST_EMPTY;
                result.last         <= 1'b1;
            end
            if (state_reg == S_MUL && (lo_reg == hi_reg || degen_reg))
            begin
                result_valid        <= 1'b1;
                result.column       <= 3'(col_reg);
                result.result_value <= (lo_reg == hi_reg) ? $signed(smp_rdata) : '0;
                result.status       <= (lo_reg == hi_reg) ? ST_OK : ST_DEGEN;
                result.last         <= last_col;
            end
            if (state_reg == S_DIV && div_done)
            begin
                result_valid        <= 1'b1;
                result.column       <= 3'(col_reg);
                result.result_value <= sum_sat;
                result.status       <= ST_OK;
                result.last         <= last_col;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                target_reg <= cmd.value;
                n_reg      <= n_eff;
                nc_reg     <= nc_eff;
                lo_reg     <= '0;
                hi_reg     <= '0;
                col_reg    <= '0;
                degen_reg  <= 1'b0;
            end
            S_CKF:
            begin
                xlo_reg <= rd_val;
            end
            S_CKL:
            begin
                if (above_last)
                begin
                    lo_reg <= n_reg[ROW_W-1:0] - 1'b1;
                    hi_reg <= n_reg[ROW_W-1:0] - 1'b1;
                end
                else
                begin
                    hi_reg     <= n_reg[ROW_W-1:0] - 1'b1;
                    dt_neg_reg <= dt_full < 0;
                    dt_mag_reg <= 32'(dt_full < 0 ? -dt_full : dt_full);
                    dx_neg_reg <= dx_full < 0;
                    dx_mag_reg <= 32'(dx_full < 0 ? -dx_full : dx_full);
                end
            end
            S_SRD:
            begin
                degen_reg <= dx_mag_reg == 0 || dx_mag_reg < {1'b0, min_spacing_reg};
            end
            S_SCK:
            begin
                // narrowing the bracket moves one end and its gap
                if (go_low)
                begin
                    lo_reg     <= mid;
                    xlo_reg    <= rd_val;
                    dt_neg_reg <= dt_mid < 0;
                    dt_mag_reg <= 32'(dt_mid < 0 ? -dt_mid : dt_mid);
                    dx_neg_reg <= dx_mid < 0;
                    dx_mag_reg <= 32'(dx_mid < 0 ? -dx_mid : dx_mid);
                end
                else
                begin
                    hi_reg     <= mid;
                    dx_neg_reg <= dx_full < 0;
                    dx_mag_reg <= 32'(dx_full < 0 ? -dx_full : dx_full);
                end
            end
            S_Y1:
            begin
                y0_reg <= $signed(smp_rdata);
            end
            S_MUL:
            begin
                dy_mag_reg <= 32'(dy_full < 0 ? -dy_full : dy_full);
                neg_reg    <= ((dy_full < 0) ^ dt_neg_reg) ^ dx_neg_reg;
                if (lo_reg == hi_reg || degen_reg)
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            S_PROD:
            begin
                prod_reg <= PROD_W'(dt_mag_reg) * PROD_W'(dy_mag_reg);
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    ap_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_EMPTY |-> result.last && result.column == 0)
        else $error("empty-table item not single");

    ap_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_DEGEN |-> result.result_value == 0)
        else $error("degenerate item carries a value");

    ap_lookup_acts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.operation == OP_LOOKUP |=> busy || result_valid)
        else $error("lookup dropped");

    ap_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
        busy && state_reg != S_RDF && state_reg != S_CKF && state_reg != S_RDL
        |-> lo_reg <= hi_reg)
        else $error("search bracket inverted");

endmodule

FILE: tb/tlli_checker.sv
// tlli_checker: predicts and checks every result of table_lookup_linear_interp_unit
// depends on tlli_pkg; watches the command, config and result channels of the block
module tlli_checker
    import tlli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_t         cmd,
    input  logic        result_valid,
    input  out_t        result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    int          bp_mem [POINTS];
    int          sample_mem [POINTS*COLS];
    logic [8:0]  points_reg;
    logic [3:0]  cols_reg;
    logic        asc_reg;
    logic [30:0] spacing_reg;
    out_t        expected_q[$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    // y0 + (t-x0)*(y1-y0)/(x1-x0), magnitude product, truncating quotient clamped at 2^33
    function automatic int blend(input int y0, input int y1, input int x0, input int x1,
                                 input int t);
        longint          dt;
        longint          dy;
        longint          dx;
        longint          sum;
        longint unsigned mdt;
        longint unsigned mdy;
        longint unsigned mdx;
        longint unsigned q;
        logic            neg;
        dt  = longint'(t) - longint'(x0);
        dy  = longint'(y1) - longint'(y0);
        dx  = longint'(x1) - longint'(x0);
        neg = ((dt < 0) != (dy < 0)) != (dx < 0);
        mdt = (dt < 0) ? -dt : dt;
        mdy = (dy < 0) ? -dy : dy;
        mdx = (dx < 0) ? -dx : dx;
        q   = (mdt * mdy) / mdx;
        if (q > 64'h2_0000_0000)
            q = 64'h2_0000_0000;
        sum = longint'(y0) + (neg ? -longint'(q) : longint'(q));
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return int'(sum);
    endfunction

    task automatic predict_lookup(input int t);
        int     n;
        int     nc;
        int     lo;
        int     hi;
        int     mid;
        longint gap;
        logic   degen;
        out_t   e;
        n  = (points_reg > POINTS) ? POINTS : points_reg;
        nc = (cols_reg > COLS) ? COLS : cols_reg;
        if (n == 0 || nc == 0)
        begin
            e = '{column: '0, result_value: '0, status: ST_EMPTY, last: 1'b1};
            expected_q.push_back(e);
            return;
        end
        // bracket search, clamping outside the breakpoint range
        if (n == 1 || (asc_reg ? t <= bp_mem[0] : t >= bp_mem[0]))
        begin
            lo = 0;
            hi = 0;
        end
        else if (asc_reg ? t >= bp_mem[n-1] : t <= bp_mem[n-1])
        begin
            lo = n - 1;
            hi = n - 1;
        end
        else
        begin
            lo = 0;
            hi = n - 1;
            while (lo + 1 < hi)
            begin
                mid = (lo + hi) / 2;
                if (asc_reg ? bp_mem[mid] <= t : bp_mem[mid] >= t)
                    lo = mid;
                else
                    hi = mid;
            end
        end
        gap   = longint'(bp_mem[hi]) - longint'(bp_mem[lo]);
        gap   = (gap < 0) ? -gap : gap;
        degen = (gap == 0) || (gap < longint'(spacing_reg));
        for (int c = 0; c < nc; c++)
        begin
            e.column = 3'(c);
            e.last   = (c + 1 == nc);
            if (lo == hi)
            begin
                e.result_value = sample_mem[lo*COLS + c];
                e.status       = ST_OK;
            end
            else if (degen)
            begin
                e.result_value = '0;
                e.status       = ST_DEGEN;
            end
            else
            begin
                e.result_value = blend(sample_mem[lo*COLS + c], sample_mem[hi*COLS + c],
                                       bp_mem[lo], bp_mem[hi], t);
                e.status       = ST_OK;
            end
            expected_q.push_back(e);
        end
    endtask

    task automatic check_result(input out_t got);
        out_t e;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: col %0d val %0d status %0d last %0d",
                         got.column, got.result_value, got.status, got.last);
            return;
        end
        e = expected_q.pop_front();
        if (got.column !== e.column || got.result_value !== e.result_value
            || got.status !== e.status || got.last !== e.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp col %0d val %0d status %0d last %0d,",
                         e.column, e.result_value, e.status, e.last,
                         " got col %0d val %0d status %0d last %0d",
                         got.column, got.result_value, got.status, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg  <= '0;
            cols_reg    <= '0;
            asc_reg     <= 1'b1;
            spacing_reg <= 31'd1;
        end
        else
        begin
            if (result_valid)
                check_result(result);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NUM_POINTS:  points_reg  <= cfg_data[8:0];
                    CFG_NUM_COLUMNS: cols_reg    <= cfg_data[3:0];
                    CFG_ASCENDING:   asc_reg     <= cfg_data[0];
                    CFG_MIN_SPACING: spacing_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (cmd.operation)
                    OP_LOAD_BP:   bp_mem[cmd.row_index] = cmd.value;
                    OP_LOAD_DATA: sample_mem[cmd.row_index*COLS + cmd.column_index] = cmd.value;
                    OP_LOOKUP:    predict_lookup(cmd.value);
                    default: ;
                endcase
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: tb/tb_table_lookup_linear_interp_unit.sv
// tb_table_lookup_linear_interp_unit: stimulus and verdict for the lookup table unit
// depends on tlli_pkg, table_lookup_linear_interp_unit and tlli_checker
module tb_table_lookup_linear_interp_unit
    import tlli_pkg::*;
;

    localparam int INT_MIN = 32'sh8000_0000;
    localparam int INT_MAX = 32'sh7FFF_FFFF;
    // operation code with no meaning, must be ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         cmd;
    logic        result_valid;
    out_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          mismatches;
    int          pending;

    // mirror of the breakpoints, used to aim targets and in some tests as the loaded values
    int          bp_val [POINTS];
    int          rows_used;
    int          cols_used;
    int          idle_pct;
    int          lookups_sent;
    int          loads_sent;
    int          configs_seen;

    table_lookup_linear_interp_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tlli_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(12 * 3000000);
        $display("Mismatches found");
        $finish;
    end

    // every call starts and ends at a falling edge; start stays high between
    // back-to-back items, so it is never lowered and raised in one step
    task automatic send_item(input logic [1:0] op, input int row, input int col, input int val);
        logic ok;
        in_t  c;
        c.operation    = op;
        c.row_index    = row[7:0];
        c.column_index = col[2:0];
        c.value        = val;
        start <= 1'b1;
        cmd   <= c;
        // busy only moves at rising edges, so its value now decides the coming edge
        do
        begin
            ok = !busy;
            @(negedge clk);
        end
        while (!ok);
        if (op == OP_LOOKUP)
            lookups_sent++;
        else
            loads_sent++;
        // each cycle idles with the phase's probability
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic write_cfg(input logic [1:0] idx, input int data);
        logic ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            ok = cfg_ready;
            @(negedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // wait for the block to go quiet, with nothing expected and busy low
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic set_table_shape(input int n, input int nc, input logic asc, input int gap);
        write_cfg(CFG_NUM_POINTS, n);
        write_cfg(CFG_NUM_COLUMNS, nc);
        write_cfg(CFG_ASCENDING, asc);
        write_cfg(CFG_MIN_SPACING, gap);
        rows_used = (n > POINTS) ? POINTS : n;
        cols_used = (nc > COLS) ? COLS : nc;
        configs_seen++;
    endtask

    function automatic int rand_value(input int span_bits);
        if (span_bits >= 32)
            return int'($urandom);
        return int'($urandom_range(0, (1 << span_bits) - 1)) - (1 << (span_bits - 1));
    endfunction

    // breakpoints sorted, sorted with repeats, or left unordered; data wide or narrow
    task automatic fill_table(input logic asc);
        int q[$];
        int bits;
        int kind;
        int base;
        kind = $urandom_range(0, 9);
        bits = ($urandom_range(0, 1) != 0) ? 32 : $urandom_range(8, 24);
        base = rand_value(bits >= 32 ? 32 : 28);
        for (int i = 0; i < rows_used; i++)
        begin
            if (kind == 0 && i > 0 && $urandom_range(0, 3) == 0)
                q.push_back(q[i-1]);
            else if (bits >= 32)
                q.push_back(rand_value(32));
            else
                q.push_back(base + rand_value(bits));
        end
        if (kind != 9)
        begin
            if (asc)
                q.sort();
            else
                q.rsort();
        end
        for (int i = 0; i < rows_used; i++)
        begin
            bp_val[i] = q[i];
            send_item(OP_LOAD_BP, i, 0, q[i]);
        end
        for (int i = 0; i < rows_used; i++)
            for (int c = 0; c < cols_used; c++)
                send_item(OP_LOAD_DATA, i, c, rand_value($urandom_range(0, 1) ? 32 : 20));
    endtask

    function automatic int pick_target();
        int r;
        int k;
        longint mix;
        r = $urandom_range(0, 9);
        k = (rows_used > 0) ? $urandom_range(0, rows_used - 1) : 0;
        case (r)
            0: return INT_MIN;
            1: return INT_MAX;
            2, 3: return int'($urandom);
            4: return bp_val[k];
            5: return bp_val[k] + $urandom_range(0, 2) - 1;
            default:
            begin
                // somewhere between two neighboring breakpoints
                if (rows_used < 2)
                    return int'($urandom);
                k = $urandom_range(0, rows_used - 2);
                mix = longint'(bp_val[k])
                    + ((longint'(bp_val[k+1]) - longint'(bp_val[k]))
                       * longint'($urandom_range(0, 1000))) / 1000;
                return int'(mix);
            end
        endcase
    endfunction

    initial
    begin
        int n_list  [10];
        int nc_list [10];
        int gap;
        int op_pick;
        logic asc;

        n_list       = '{2, 3, 5, 4, 16, 1, 20, 9, 4, 12};
        nc_list      = '{8, 1, 3, 15, 2, 5, 2, 2, 7, 1};
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_pct     = 0;
        rows_used    = 0;
        cols_used    = 0;
        lookups_sent = 0;
        loads_sent   = 0;
        configs_seen = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table under reset settings, then with columns but no points
        send_item(OP_LOOKUP, 0, 0, 0);
        send_item(OP_UNUSED, 255, 7, -1);
        drain();
        write_cfg(CFG_NUM_COLUMNS, 3);
        send_item(OP_LOOKUP, 0, 0, INT_MAX);
        drain();

        // single point: row 0 comes back unchanged for any target
        set_table_shape(1, 3, 1'b1, 1);
        send_item(OP_LOAD_BP, 0, 0, 12345);
        send_item(OP_LOAD_DATA, 0, 0, INT_MIN);
        send_item(OP_LOAD_DATA, 0, 1, INT_MAX);
        send_item(OP_LOAD_DATA, 0, 2, -7);
        send_item(OP_LOOKUP, 0, 0, INT_MIN);
        send_item(OP_LOOKUP, 0, 0, INT_MAX);
        drain();

        // four points across the full range with saturating data
        set_table_shape(4, 1, 1'b1, 1);
        bp_val[0] = INT_MIN;
        bp_val[1] = -5;
        bp_val[2] = 7;
        bp_val[3] = INT_MAX;
        for (int i = 0; i < 4; i++)
        begin
            send_item(OP_LOAD_BP, i, 0, bp_val[i]);
            send_item(OP_LOAD_DATA, i, 0, (i % 2) ? INT_MIN : INT_MAX);
        end
        send_item(OP_LOOKUP, 0, 0, INT_MIN);
        send_item(OP_LOOKUP, 0, 0, INT_MAX);
        send_item(OP_LOOKUP, 0, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 7);
        send_item(OP_LOOKUP, 0, 0, 1000000000);
        drain();
        // every interior bracket now too narrow
        write_cfg(CFG_MIN_SPACING, INT_MAX);
        send_item(OP_LOOKUP, 0, 0, 0);
        drain();
        // same breakpoints read as descending: the search runs on an unordered column
        write_cfg(CFG_ASCENDING, 0);
        write_cfg(CFG_MIN_SPACING, 0);
        send_item(OP_LOOKUP, 0, 0, 3);
        send_item(OP_LOOKUP, 0, 0, -100);
        drain();
        // point count above the table size, target clamped to the first row
        write_cfg(CFG_ASCENDING, 1);
        write_cfg(CFG_NUM_POINTS, 300);
        send_item(OP_LOOKUP, 0, 0, INT_MIN);
        drain();

        // random phases, each with its own table shape and one of three idling patterns
        for (int p = 0; p < 10; p++)
        begin
            asc = $urandom_range(0, 1);
            case ($urandom_range(0, 4))
                0: gap = 0;
                1: gap = 1;
                2: gap = $urandom_range(0, 65535);
                3: gap = $urandom_range(0, 1 << 24);
                default: gap = INT_MAX;
            endcase
            idle_pct = 0;
            set_table_shape(n_list[p], nc_list[p], asc, gap);
            fill_table(asc);
            case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 87;
                2: idle_pct = 0;
                default: idle_pct = 23;
            endcase
            for (int i = 0; i < 6; i++)
            begin
                op_pick = $urandom_range(0, 19);
                if (op_pick < 15)
                    send_item(OP_LOOKUP, 0, 0, pick_target());
                else if (op_pick < 17)
                    send_item(OP_LOAD_DATA, $urandom_range(0, rows_used - 1),
                              $urandom_range(0, cols_used - 1), int'($urandom));
                else if (op_pick == 17)
                begin
                    // moves one breakpoint, possibly breaking the ordering
                    op_pick = $urandom_range(0, rows_used - 1);
                    bp_val[op_pick] = int'($urandom);
                    send_item(OP_LOAD_BP, op_pick, 0, bp_val[op_pick]);
                end
                else if (op_pick == 18)
                    send_item(OP_LOAD_DATA, $urandom_range(0, 255), $urandom_range(0, 7),
                              int'($urandom));
                else
                    send_item(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 7),
                              int'($urandom));
            end
            drain();
        end

        $display("covered %0d lookups and %0d loads over %0d table shapes",
                 lookups_sent, loads_sent, configs_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
